>>> rtl/dpfr_pkg.sv
// Shared types and constants for the demand paging frame replacer.
`timescale 1ns / 1ps
package dpfr_pkg;
  localparam int FRAMES = 16;
  localparam int PAGES = 64;
  localparam int JOBS = 16;
  localparam logic [12:0] RESET_PAGE_SIZE = 13'd200;
  localparam logic [12:0] MAX_PAGE_SIZE = 13'd4096;
  localparam logic REPLACE_FIFO = 1'b0;
  localparam logic REPLACE_LRU = 1'b1;
  localparam logic CFG_REPLACE_MODE = 1'b0;
  localparam logic CFG_PAGE_SIZE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOKUP, ST_SCAN, ST_EVICT, ST_UPDATE, ST_DIV, ST_MUL, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic lookup;
    logic scan_step;
    logic evict;
    logic update;
    logic div_start;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_done;
    logic found_free;
    logic div_done;
  } sts_t;
endpackage

>>> rtl/dpfr_ctrl.sv
// Sequencer for one page request.
`timescale 1ns / 1ps
module dpfr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_busy,
  input  dpfr_pkg::sts_t   sts,
  output dpfr_pkg::cmd_t   cmd
);
  dpfr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= dpfr_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      dpfr_pkg::ST_IDLE:   if (in_valid) state_next = dpfr_pkg::ST_LOOKUP;
      dpfr_pkg::ST_LOOKUP: state_next = sts.hit ? dpfr_pkg::ST_UPDATE : dpfr_pkg::ST_SCAN;
      dpfr_pkg::ST_SCAN:   if (sts.scan_done)
                             state_next = sts.found_free ? dpfr_pkg::ST_UPDATE
                                                         : dpfr_pkg::ST_EVICT;
      dpfr_pkg::ST_EVICT:  state_next = dpfr_pkg::ST_UPDATE;
      dpfr_pkg::ST_UPDATE: state_next = dpfr_pkg::ST_DIV;
      dpfr_pkg::ST_DIV:    if (sts.div_done) state_next = dpfr_pkg::ST_MUL;
      dpfr_pkg::ST_MUL:    state_next = dpfr_pkg::ST_OUT;
      dpfr_pkg::ST_OUT:    if (!out_busy) state_next = dpfr_pkg::ST_IDLE;
      default:             state_next = dpfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = (state != dpfr_pkg::ST_IDLE);
    case (state)
      dpfr_pkg::ST_IDLE:   cmd.start = in_valid;
      dpfr_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
      dpfr_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
      dpfr_pkg::ST_EVICT:  cmd.evict = 1'b1;
      dpfr_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        cmd.div_start = 1'b1;
      end
      dpfr_pkg::ST_DIV:    cmd.div_step = 1'b1;
      dpfr_pkg::ST_MUL:    cmd.mul = 1'b1;
      dpfr_pkg::ST_OUT:    cmd.out_load = !out_busy;
      default:             cmd = '0;
    endcase
  end
endmodule

>>> rtl/dpfr_datapath.sv
// Page table, frame table, victim scan, restoring divider and address build.
`timescale 1ns / 1ps
module dpfr_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  dpfr_pkg::cmd_t              cmd,
  output dpfr_pkg::sts_t              sts,
  input  logic                        replace_mode,
  input  logic [12:0]                 pg_bytes,
  input  logic [5:0]                  page_number,
  input  logic [3:0]                  job_id,
  input  logic [15:0]                 virt_addr,
  output logic                        r_hit,
  output logic [3:0]                  r_frame,
  output logic                        r_evicted,
  output logic [5:0]                  r_ev_page,
  output logic [3:0]                  r_ev_job,
  output logic [11:0]                 r_offset,
  output logic [15:0]                 r_phys
);
  localparam int FW = $clog2(dpfr_pkg::FRAMES);
  localparam int PW = $clog2(dpfr_pkg::PAGES);
  localparam int JW = (dpfr_pkg::JOBS > 1) ? $clog2(dpfr_pkg::JOBS) : 1;

  logic [dpfr_pkg::PAGES-1:0]  page_valid;
  logic [FW-1:0]               page_frame [dpfr_pkg::PAGES];
  logic [dpfr_pkg::FRAMES-1:0] frame_occupied;
  logic [PW-1:0]               owner_page [dpfr_pkg::FRAMES];
  logic [JW-1:0]               owner_job [dpfr_pkg::FRAMES];
  logic [31:0]                 load_stamp [dpfr_pkg::FRAMES];
  logic [31:0]                 use_stamp [dpfr_pkg::FRAMES];
  logic [31:0]                 request_counter;

  logic [PW-1:0]  req_page;
  logic [JW-1:0]  req_job;
  logic [15:0]    req_addr;
  logic [31:0]    now;
  logic           hit;
  logic [FW-1:0]  frame;
  logic [FW:0]    scan_idx;
  logic           found;
  logic [31:0]    best_age;
  logic [FW-1:0]  best;
  logic           evicted;
  logic [PW-1:0]  ev_page;
  logic [JW-1:0]  ev_job;
  logic [12:0]    ps;
  logic [12:0]    rem;
  logic [15:0]    dividend;
  logic [4:0]     div_cnt;
  logic [15:0]    phys;

  logic [FW-1:0] sidx;
  logic [31:0]   stamp_sel;
  logic [31:0]   age;
  logic [13:0]   trial;
  logic [12:0]   ps_clip;

  assign sidx = scan_idx[FW-1:0];
  assign stamp_sel = replace_mode ? use_stamp[sidx] : load_stamp[sidx];
  assign age = now - stamp_sel;
  assign trial = {rem, dividend[15]} - {1'b0, ps};

  always_comb begin
    if (pg_bytes == 13'd0) ps_clip = 13'd1;
    else if (pg_bytes > dpfr_pkg::MAX_PAGE_SIZE) ps_clip = dpfr_pkg::MAX_PAGE_SIZE;
    else ps_clip = pg_bytes;
  end

  assign sts.hit = page_valid[req_page];
  assign sts.scan_done = found || (scan_idx == (FW+1)'(dpfr_pkg::FRAMES));
  assign sts.found_free = found;
  assign sts.div_done = (div_cnt == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
      frame_occupied <= '0;
      request_counter <= '0;
    end else begin
      if (cmd.start) begin
        req_page <= PW'(page_number);
        req_job <= JW'(job_id);
        req_addr <= virt_addr;
        now <= request_counter;
        request_counter <= request_counter + 32'd1;
        scan_idx <= '0;
        found <= 1'b0;
        evicted <= 1'b0;
        ev_page <= '0;
        ev_job <= '0;
      end
      if (cmd.lookup) begin
        hit <= page_valid[req_page];
        frame <= page_frame[req_page];
      end
      if (cmd.scan_step && !sts.scan_done) begin
        if (!frame_occupied[sidx]) begin
          found <= 1'b1;
          frame <= sidx;
        end else if (scan_idx == '0 || age > best_age) begin
          best_age <= age;
          best <= sidx;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.evict) begin
        frame <= best;
        evicted <= 1'b1;
        ev_page <= owner_page[best];
        ev_job <= owner_job[best];
        page_valid[owner_page[best]] <= 1'b0;
      end
      if (cmd.update) begin
        use_stamp[frame] <= now;
        if (!hit) begin
          frame_occupied[frame] <= 1'b1;
          owner_page[frame] <= req_page;
          owner_job[frame] <= req_job;
          load_stamp[frame] <= now;
          page_valid[req_page] <= 1'b1;
          page_frame[req_page] <= frame;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle; only the remainder is kept
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      ps <= ps_clip;
      rem <= '0;
      dividend <= req_addr;
      div_cnt <= 5'd16;
    end else if (cmd.div_step && div_cnt != 5'd0) begin
      if (!trial[13]) rem <= trial[12:0];
      else rem <= {rem[11:0], dividend[15]};
      dividend <= {dividend[14:0], 1'b0};
      div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) phys <= 16'(32'(frame) * 32'(ps) + 32'(rem));
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      r_hit <= hit;
      r_frame <= 4'(frame);
      r_evicted <= evicted;
      r_ev_page <= 6'(ev_page);
      r_ev_job <= 4'(ev_job);
      r_offset <= rem[11:0];
      r_phys <= phys;
    end
  end
endmodule

>>> rtl/demand_paging_frame_replacer.sv
// Top level of the demand paging frame replacer.
// One page request at a time. On a hit the item goes through lookup, update, the divider,
// the address multiply and the output state before the next item can be taken. A miss adds
// the frame table scan, which stops at the lowest free frame, or runs over every frame and
// adds an eviction when every frame is taken. The sequential remainder divider (16 steps)
// and the frame scan set the time per item; a stalled result holds up the next one only
// when the next result is ready behind it. The result sits in an output register, so the
// next item is taken while it waits. Valid bits reset at once; no clearing pass.
`timescale 1ns / 1ps
module demand_paging_frame_replacer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  page_number,
  input  logic [3:0]  job_id,
  input  logic [15:0] virt_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [3:0]  frame_number,
  output logic        evicted,
  output logic [5:0]  evicted_page,
  output logic [3:0]  evicted_job,
  output logic [11:0] page_offset,
  output logic [15:0] physical_address,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  dpfr_pkg::cmd_t cmd;
  dpfr_pkg::sts_t sts;
  logic        replace_mode;
  logic [12:0] pg_bytes;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_mode <= dpfr_pkg::REPLACE_FIFO;
      pg_bytes <= dpfr_pkg::RESET_PAGE_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        dpfr_pkg::CFG_REPLACE_MODE: replace_mode <= cfg_data[0];
        dpfr_pkg::CFG_PAGE_SIZE:    pg_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // output item register: filled by the datapath, held while stalled
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  dpfr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_valid && out_stall), .sts(sts), .cmd(cmd)
  );

  dpfr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .replace_mode(replace_mode), .pg_bytes(pg_bytes),
    .page_number(page_number), .job_id(job_id),
    .virt_addr(virt_addr),
    .r_hit(hit), .r_frame(frame_number), .r_evicted(evicted),
    .r_ev_page(evicted_page), .r_ev_job(evicted_job),
    .r_offset(page_offset), .r_phys(physical_address)
  );
endmodule

>>> rtl/dpfr_checker.sv
// Port-level checks for the frame replacer, bound to the top level.
`timescale 1ns / 1ps
module dpfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic        evicted,
  input logic [15:0] physical_address
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(physical_address))
    else $error("stalled result changed");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted))
    else $error("hit with eviction");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted two items back to back");
  a_no_out_soon: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too soon");
endmodule

bind demand_paging_frame_replacer dpfr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .hit(hit), .evicted(evicted),
  .physical_address(physical_address)
);
